@@ rtl/core/gsi_pkg.sv @@
// Shared types and constants of the gain schedule interpolator.
package gsi_pkg;

    localparam int TableRows = 16;
    localparam int IdxW      = $clog2(TableRows);
    localparam int CntW      = $clog2(TableRows + 1);
    localparam int SpeedW    = 16;
    localparam int ValW      = 32;
    localparam int FracW     = 16;
    localparam int DivSteps  = FracW + 1;
    localparam int StepW     = $clog2(DivSteps + 1);
    localparam int ProdW     = ValW + 1 + FracW;
    localparam int InDataW   = SpeedW + 4 * ValW;
    localparam int OutDataW  = 4 * ValW;

    localparam logic KindInsert = 1'b0;
    localparam logic KindLookup = 1'b1;

    typedef struct packed {
        logic signed [SpeedW-1:0] speed;
        logic signed [ValW-1:0]   gain_p;
        logic signed [ValW-1:0]   gain_i;
        logic signed [ValW-1:0]   gain_d;
        logic signed [ValW-1:0]   rate_cap;
    } t_row;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
        t_row            data;
    } t_wr_req;

    typedef enum logic [1:0] {
        StatOk    = 2'd0,
        StatEmpty = 2'd1,
        StatFull  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        StIdle,
        StScanRd,
        StScanCmp,
        StResolve,
        StShiftRd,
        StShiftWr,
        StWrite,
        StDiv,
        StMul,
        StDone
    } t_state;

endpackage

@@ rtl/core/gain_schedule_interpolator_core.sv @@
// Speed-indexed gain table with piecewise linear lookup, top level.
//
// Each request is handled on its own from start to finish. Both kinds first
// scan the sorted table from row 0 until the first row whose speed is at or
// above the request speed. An insert then moves the rows above its slot up
// by one and writes the new row; a row of equal speed is overwritten in
// place, and a full table drops the insert. A lookup that lands between two
// rows runs a 17-step radix-2 divide for the Q0.16 fraction and then 16
// steps of four bit-serial multiply lanes; one that holds an end row returns
// it as stored. A new request is taken while the previous result still
// waits in the output register.
module gain_schedule_interpolator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // speed[15:0], gain_p[47:16], gain_i[79:48], gain_d[111:80], rate_cap[143:112]
    input  logic [gsi_pkg::InDataW-1:0]      s_axis_tdata,
    // kind[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_p[31:0], out_i[63:32], out_d[95:64], out_cap[127:96]
    output logic [gsi_pkg::OutDataW-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [1:0]                       m_axis_tuser
);
    import gsi_pkg::*;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_idx;
    logic [CntW-1:0] r_pos;
    logic [CntW-1:0] idx_dec;
    logic            r_kind;
    logic            r_eq;
    t_row            r_in;
    t_row            r_lo;
    t_row            r_hi;
    t_status         r_res_status;
    logic [ValW-1:0] r_res_p, r_res_i, r_res_d, r_res_cap;

    logic              r_m_valid;
    logic [OutDataW-1:0] r_m_data;
    logic [1:0]        r_m_user;

    t_wr_req         wr;
    logic [IdxW-1:0] raddr;
    t_row            rdata;
    logic            div_start, div_done;
    logic [FracW-1:0] frac;
    logic            mul_start;
    logic            mul_done_p, mul_done_i, mul_done_d, mul_done_c;
    logic signed [ValW-1:0] mul_p, mul_i, mul_d, mul_c;
    logic            accept;
    logic            out_load;
    logic            found;
    logic            hold_row;
    logic signed [SpeedW:0] num_w, den_w;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign idx_dec  = r_idx - 1'b1;
    assign found    = r_idx != r_count;
    assign out_load = (r_state == StDone) && (!r_m_valid || m_axis_tready);
    // end rows are returned as stored; an exact hit on the last row counts too
    assign hold_row = !found || (r_idx == '0) || (r_eq && (r_idx + 1'b1 == r_count));
    assign num_w    = {r_in.speed[SpeedW-1], r_in.speed} - {r_lo.speed[SpeedW-1], r_lo.speed};
    assign den_w    = {r_hi.speed[SpeedW-1], r_hi.speed} - {r_lo.speed[SpeedW-1], r_lo.speed};

    gsi_table u_table (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_w[FracW-1:0]),
        .i_den   (den_w[FracW-1:0]),
        .o_done  (div_done),
        .o_frac  (frac)
    );

    gsi_mul u_mul_p (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_start), .i_frac (frac),
        .i_lo (r_lo.gain_p), .i_hi (r_hi.gain_p), .o_done (mul_done_p), .o_val (mul_p)
    );

    gsi_mul u_mul_i (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_start), .i_frac (frac),
        .i_lo (r_lo.gain_i), .i_hi (r_hi.gain_i), .o_done (mul_done_i), .o_val (mul_i)
    );

    gsi_mul u_mul_d (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_start), .i_frac (frac),
        .i_lo (r_lo.gain_d), .i_hi (r_hi.gain_d), .o_done (mul_done_d), .o_val (mul_d)
    );

    gsi_mul u_mul_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_start), .i_frac (frac),
        .i_lo (r_lo.rate_cap), .i_hi (r_hi.rate_cap), .o_done (mul_done_c), .o_val (mul_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        raddr         = r_idx[IdxW-1:0];
        wr.en         = 1'b0;
        wr.addr       = r_pos[IdxW-1:0];
        wr.data       = r_in;
        div_start     = 1'b0;
        mul_start     = 1'b0;
        unique case (r_state)
            StIdle: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = StScanRd;
                end
            end
            StScanRd: begin
                if (r_idx == r_count) begin
                    n_state = StResolve;
                end else begin
                    n_state = StScanCmp;
                end
            end
            StScanCmp: begin
                if ($signed(rdata.speed) >= $signed(r_in.speed)) begin
                    n_state = StResolve;
                end else begin
                    n_state = StScanRd;
                end
            end
            StResolve: begin
                if (r_kind == KindInsert) begin
                    if (found && r_eq) begin
                        n_state = StWrite;
                    end else if (r_count == CntW'(TableRows)) begin
                        n_state = StDone;
                    end else begin
                        n_state = StShiftRd;
                    end
                end else begin
                    if (r_count == '0 || hold_row) begin
                        n_state = StDone;
                    end else begin
                        div_start = 1'b1;
                        n_state   = StDiv;
                    end
                end
            end
            StShiftRd: begin
                raddr = idx_dec[IdxW-1:0];
                if (r_idx == r_pos) begin
                    n_state = StWrite;
                end else begin
                    n_state = StShiftWr;
                end
            end
            StShiftWr: begin
                wr.en   = 1'b1;
                wr.addr = r_idx[IdxW-1:0];
                wr.data = rdata;
                n_state = StShiftRd;
            end
            StWrite: begin
                wr.en   = 1'b1;
                n_state = StDone;
            end
            StDiv: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = StMul;
                end
            end
            StMul: begin
                if (mul_done_p) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    // row count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == StWrite && !r_eq) begin
            r_count <= r_count + 1'b1;
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind         <= s_axis_tuser;
            r_in.speed     <= s_axis_tdata[SpeedW-1:0];
            r_in.gain_p    <= s_axis_tdata[SpeedW+ValW-1:SpeedW];
            r_in.gain_i    <= s_axis_tdata[SpeedW+2*ValW-1:SpeedW+ValW];
            r_in.gain_d    <= s_axis_tdata[SpeedW+3*ValW-1:SpeedW+2*ValW];
            r_in.rate_cap  <= s_axis_tdata[SpeedW+4*ValW-1:SpeedW+3*ValW];
            r_idx          <= '0;
            r_eq           <= 1'b0;
            r_res_status   <= StatOk;
            r_res_p        <= '0;
            r_res_i        <= '0;
            r_res_d        <= '0;
            r_res_cap      <= '0;
        end else begin
            unique case (r_state)
                StScanCmp: begin
                    r_lo <= r_hi;
                    r_hi <= rdata;
                    r_eq <= rdata.speed == r_in.speed;
                    if ($signed(rdata.speed) < $signed(r_in.speed)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                StResolve: begin
                    r_pos <= r_idx;
                    if (r_kind == KindInsert) begin
                        r_idx <= r_count;
                        if (!(found && r_eq) && r_count == CntW'(TableRows)) begin
                            r_res_status <= StatFull;
                        end
                    end else if (r_count == '0) begin
                        r_res_status <= StatEmpty;
                    end else if (hold_row) begin
                        r_res_p   <= r_hi.gain_p;
                        r_res_i   <= r_hi.gain_i;
                        r_res_d   <= r_hi.gain_d;
                        r_res_cap <= r_hi.rate_cap;
                    end
                end
                StShiftWr: begin
                    r_idx <= idx_dec;
                end
                StMul: begin
                    if (mul_done_p && mul_done_i && mul_done_d && mul_done_c) begin
                        r_res_p   <= mul_p;
                        r_res_i   <= mul_i;
                        r_res_d   <= mul_d;
                        r_res_cap <= mul_c;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_res_cap, r_res_d, r_res_i, r_res_p};
            r_m_user <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

@@ rtl/core/gsi_table.sv @@
// Breakpoint row storage: one write port, one registered read port.
module gsi_table (
    input  logic                       i_clk,
    input  gsi_pkg::t_wr_req           i_wr,
    input  logic [gsi_pkg::IdxW-1:0]   i_raddr,
    output gsi_pkg::t_row              o_rdata
);
    import gsi_pkg::*;

    t_row r_mem [TableRows];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/gsi_div.sv @@
// Radix-2 restoring divider producing the Q0.16 interpolation fraction.
module gsi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gsi_pkg::FracW-1:0]   i_num,
    input  logic [gsi_pkg::FracW-1:0]   i_den,
    output logic                        o_done,
    output logic [gsi_pkg::FracW-1:0]   o_frac
);
    import gsi_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [StepW-1:0] r_cnt, n_cnt;
    logic [FracW:0]   r_rem;
    logic [FracW-1:0] r_den;
    logic [FracW:0]   r_q;
    logic             ge;
    logic [FracW:0]   rem_sub;

    // numerator never exceeds the span, so the remainder stays below 2^17
    assign ge      = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = StepW'(DivSteps);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == StepW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_sub[FracW-1:0], 1'b0};
            r_q   <= {r_q[FracW-1:0], ge};
        end
    end

    assign o_done = r_done;
    // clamp a full-span quotient to the largest fraction
    assign o_frac = r_q[FracW] ? {FracW{1'b1}} : r_q[FracW-1:0];

endmodule

@@ rtl/core/gsi_mul.sv @@
// Bit-serial interpolation lane: lo + floor(t * (hi - lo) / 2^16).
module gsi_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [gsi_pkg::FracW-1:0]        i_frac,
    input  logic signed [gsi_pkg::ValW-1:0]  i_lo,
    input  logic signed [gsi_pkg::ValW-1:0]  i_hi,
    output logic                             o_done,
    output logic signed [gsi_pkg::ValW-1:0]  o_val
);
    import gsi_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [StepW-1:0]        r_cnt, n_cnt;
    logic [FracW-1:0]        r_t;
    logic signed [ValW:0]    r_diff;
    logic signed [ValW-1:0]  r_lo;
    logic signed [ProdW-1:0] r_acc;
    logic signed [ProdW-1:0] addend;

    assign addend = r_t[FracW-1] ? {{(ProdW-ValW-1){r_diff[ValW]}}, r_diff} : '0;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = StepW'(FracW);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == StepW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // MSB-first shift-add over the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_t    <= i_frac;
            r_lo   <= i_lo;
            r_diff <= {i_hi[ValW-1], i_hi} - {i_lo[ValW-1], i_lo};
            r_acc  <= '0;
        end else if (r_busy) begin
            r_t   <= {r_t[FracW-2:0], 1'b0};
            r_acc <= (r_acc <<< 1) + addend;
        end
    end

    assign o_done = r_done;
    assign o_val  = r_lo + r_acc[FracW+ValW-1:FracW];

endmodule

@@ rtl/core/gsi_checker.sv @@
// Port-level checks of the gain schedule interpolator and their binding.
module gsi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gsi_pkg::OutDataW-1:0]     m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);
    import gsi_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // one request at a time: no second request right after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // an empty or full result carries all-zero values
    a_zero_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == StatEmpty || m_axis_tuser == StatFull)
        |-> m_axis_tdata == '0)
        else $error("values on empty or dropped result");

    // status code is one of the defined ones
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == StatOk || m_axis_tuser == StatEmpty ||
                           m_axis_tuser == StatFull))
        else $error("undefined status code");

endmodule

bind gain_schedule_interpolator_core gsi_checker u_gsi_checker (.*);
